>>> src/rbm_pkg.sv
// ----------------------------------------------------------------------------
// rbm_pkg: shared types and constants
// Item formats, pipeline depths and the CORDIC arctangent table for the
// range/bearing measurement model.
// ----------------------------------------------------------------------------
package rbm_pkg;

  localparam int CORDIC_STEPS = 24;   // 8..32
  localparam int SQRT_STEPS   = 32;   // one root bit per stage, 64-bit radicand
  localparam int FRONT_LAT    = 4;
  localparam int DIV_QBITS    = 34;   // quotient bits kept before saturation
  localparam int DIV_LAT      = DIV_QBITS + 1;
  localparam int Z_W          = 33;   // angle accumulator
  localparam int CX_W         = 36;   // CORDIC x/y datapath

  localparam logic signed [31:0] PI_Q29      = 32'sd1686629713;
  localparam logic signed [31:0] HALF_PI_Q29 = 32'sd843314857;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
  } pos_t;

  typedef struct packed {
    logic signed [31:0] bearing;
    logic        [31:0] range_out;
    logic signed [31:0] dbearing_dx;
    logic signed [31:0] dbearing_dy;
    logic signed [31:0] drange_dx;
    logic signed [31:0] drange_dy;
    logic               at_origin;
  } meas_t;

  typedef struct packed {
    logic at_origin;
    logic x_neg;
    logic x_zero;
    logic y_pos;
    logic y_neg;
    logic y_zero;
  } flags_t;

  typedef struct packed {
    logic        [63:0] s;
    logic        [63:0] sn;
    logic        [31:0] ax;
    logic        [31:0] ay;
    logic        [31:0] axn;
    logic        [31:0] ayn;
    logic signed [31:0] xn;
    logic signed [31:0] yn;
    flags_t             flags;
  } front_t;

  // atan(2^-i) in Q3.29, rounded to nearest
  function automatic logic signed [Z_W-1:0] atan_q29(input int i);
    logic signed [Z_W-1:0] a;
    case (i)
      0:       a = 33'sd421657428;
      1:       a = 33'sd248918915;
      2:       a = 33'sd131521918;
      3:       a = 33'sd66762579;
      4:       a = 33'sd33510843;
      5:       a = 33'sd16771758;
      6:       a = 33'sd8387925;
      7:       a = 33'sd4194219;
      8:       a = 33'sd2097141;
      9:       a = 33'sd1048575;
      10:      a = 33'sd524288;
      11:      a = 33'sd262144;
      12:      a = 33'sd131072;
      13:      a = 33'sd65536;
      14:      a = 33'sd32768;
      15:      a = 33'sd16384;
      16:      a = 33'sd8192;
      17:      a = 33'sd4096;
      18:      a = 33'sd2048;
      19:      a = 33'sd1024;
      20:      a = 33'sd512;
      21:      a = 33'sd256;
      22:      a = 33'sd128;
      23:      a = 33'sd64;
      24:      a = 33'sd32;
      25:      a = 33'sd16;
      26:      a = 33'sd8;
      27:      a = 33'sd4;
      28:      a = 33'sd2;
      29:      a = 33'sd1;
      default: a = 33'sd0;
    endcase
    return a;
  endfunction

endpackage

>>> src/rbm_front.sv
// ----------------------------------------------------------------------------
// rbm_front: magnitudes, normalization and squares
// Four stages: magnitudes and flags; normalize shift and raw squares;
// raw sum and normalized squares; normalized sum.
// ----------------------------------------------------------------------------
module rbm_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            in_valid,
  input  rbm_pkg::pos_t   pos,
  output logic            out_valid,
  output rbm_pkg::front_t res
);
  import rbm_pkg::*;

  function automatic logic [4:0] lead_zeros(input logic [31:0] v);
    logic [4:0] n;
    logic       found;
    n     = 5'd0;
    found = 1'b0;
    for (int k = 31; k >= 0; k--) begin
      if (!found) begin
        if (v[k]) found = 1'b1;
        else n = n + 5'd1;
      end
    end
    return n;
  endfunction

  logic v1, v2, v3, v4;

  logic signed [31:0] x1, y1;
  logic        [31:0] ax1, ay1;
  flags_t             fl1;

  logic        [31:0] ax2, ay2, axn2, ayn2;
  logic signed [31:0] xn2, yn2;
  logic        [63:0] pax2, pay2;
  flags_t             fl2;

  logic        [31:0] ax3, ay3, axn3, ayn3;
  logic signed [31:0] xn3, yn3;
  logic        [63:0] s3, paxn3, payn3;
  flags_t             fl3;

  logic [31:0] m1;
  logic [4:0]  lz1, sh1;

  always_comb begin
    m1  = (ax1 > ay1) ? ax1 : ay1;
    lz1 = lead_zeros(m1);
    sh1 = (m1[31] | m1[30]) ? 5'd0 : lz1 - 5'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x1            <= pos.pos_x;
      y1            <= pos.pos_y;
      ax1           <= pos.pos_x[31] ? (~pos.pos_x + 32'd1) : pos.pos_x;
      ay1           <= pos.pos_y[31] ? (~pos.pos_y + 32'd1) : pos.pos_y;
      fl1.at_origin <= (pos.pos_x == 32'sd0) && (pos.pos_y == 32'sd0);
      fl1.x_neg     <= pos.pos_x[31];
      fl1.x_zero    <= (pos.pos_x == 32'sd0);
      fl1.y_pos     <= !pos.pos_y[31] && (pos.pos_y != 32'sd0);
      fl1.y_neg     <= pos.pos_y[31];
      fl1.y_zero    <= (pos.pos_y == 32'sd0);

      ax2  <= ax1;
      ay2  <= ay1;
      axn2 <= ax1 << sh1;
      ayn2 <= ay1 << sh1;
      xn2  <= x1 <<< sh1;
      yn2  <= y1 <<< sh1;
      pax2 <= 64'(ax1) * 64'(ax1);
      pay2 <= 64'(ay1) * 64'(ay1);
      fl2  <= fl1;

      ax3   <= ax2;
      ay3   <= ay2;
      axn3  <= axn2;
      ayn3  <= ayn2;
      xn3   <= xn2;
      yn3   <= yn2;
      s3    <= pax2 + pay2;
      paxn3 <= 64'(axn2) * 64'(axn2);
      payn3 <= 64'(ayn2) * 64'(ayn2);
      fl3   <= fl2;

      res.s     <= s3;
      res.sn    <= paxn3 + payn3;
      res.ax    <= ax3;
      res.ay    <= ay3;
      res.axn   <= axn3;
      res.ayn   <= ayn3;
      res.xn    <= xn3;
      res.yn    <= yn3;
      res.flags <= fl3;
    end
  end

  assign out_valid = v4;

endmodule

>>> src/rbm_sqrt.sv
// ----------------------------------------------------------------------------
// rbm_sqrt: pipelined integer square root
// Digit-by-digit root of a 64-bit value, one root bit per stage. Returns
// the floor root and the remainder value - root^2.
// ----------------------------------------------------------------------------
module rbm_sqrt (
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  logic        in_valid,
  input  logic [63:0] rad,
  output logic        out_valid,
  output logic [31:0] root,
  output logic [33:0] rem
);
  import rbm_pkg::*;

  logic        v_s    [SQRT_STEPS];
  logic [63:0] rad_s  [SQRT_STEPS];
  logic [31:0] root_s [SQRT_STEPS];
  logic [33:0] rem_s  [SQRT_STEPS];

  for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_step
    logic        v_in;
    logic [63:0] rad_in;
    logic [31:0] root_in;
    logic [33:0] rem_in;
    logic [35:0] cand, trial;
    logic        ge;

    if (i == 0) begin : g_first
      assign v_in    = in_valid;
      assign rad_in  = rad;
      assign root_in = 32'd0;
      assign rem_in  = 34'd0;
    end else begin : g_next
      assign v_in    = v_s[i-1];
      assign rad_in  = rad_s[i-1];
      assign root_in = root_s[i-1];
      assign rem_in  = rem_s[i-1];
    end

    assign cand  = {rem_in, rad_in[63-2*i -: 2]};
    assign trial = {2'b00, root_in, 2'b01};
    assign ge    = (cand >= trial);

    always_ff @(posedge clk) begin
      if (rst) begin
        v_s[i] <= 1'b0;
      end else if (en) begin
        v_s[i] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rad_s[i]  <= rad_in;
        root_s[i] <= {root_in[30:0], ge};
        rem_s[i]  <= ge ? 34'(cand - trial) : 34'(cand);
      end
    end
  end

  assign out_valid = v_s[SQRT_STEPS-1];
  assign root      = root_s[SQRT_STEPS-1];
  assign rem       = rem_s[SQRT_STEPS-1];

endmodule

>>> src/rbm_div.sv
// ----------------------------------------------------------------------------
// rbm_div: pipelined restoring divider
// 64-bit numerator over 64-bit divisor, one quotient bit per stage. Quotients
// that do not fit in the kept bits raise the overflow flag.
// ----------------------------------------------------------------------------
module rbm_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic [63:0]                   num,
  input  logic [63:0]                   den,
  output logic                          out_valid,
  output logic [rbm_pkg::DIV_QBITS-1:0] quo,
  output logic                          ovf
);
  import rbm_pkg::*;

  logic                 v_s   [DIV_QBITS+1];
  logic [63:0]          rem_s [DIV_QBITS+1];
  logic [63:0]          den_s [DIV_QBITS+1];
  logic [DIV_QBITS-1:0] low_s [DIV_QBITS+1];
  logic [DIV_QBITS-1:0] quo_s [DIV_QBITS+1];
  logic                 ovf_s [DIV_QBITS+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v_s[0] <= 1'b0;
    end else if (en) begin
      v_s[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_s[0] <= 64'(num >> DIV_QBITS);
      ovf_s[0] <= (64'(num >> DIV_QBITS) >= den);
      low_s[0] <= num[DIV_QBITS-1:0];
      den_s[0] <= den;
      quo_s[0] <= '0;
    end
  end

  for (genvar k = 1; k <= DIV_QBITS; k++) begin : g_step
    logic [64:0] cand;
    logic        ge;

    assign cand = {rem_s[k-1], low_s[k-1][DIV_QBITS-k]};
    assign ge   = (cand >= {1'b0, den_s[k-1]});

    always_ff @(posedge clk) begin
      if (rst) begin
        v_s[k] <= 1'b0;
      end else if (en) begin
        v_s[k] <= v_s[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_s[k] <= ge ? 64'(cand - {1'b0, den_s[k-1]}) : 64'(cand);
        den_s[k] <= den_s[k-1];
        low_s[k] <= low_s[k-1];
        quo_s[k] <= {quo_s[k-1][DIV_QBITS-2:0], ge};
        ovf_s[k] <= ovf_s[k-1];
      end
    end
  end

  assign out_valid = v_s[DIV_QBITS];
  assign quo       = quo_s[DIV_QBITS];
  assign ovf       = ovf_s[DIV_QBITS];

endmodule

>>> src/rbm_cordic.sv
// ----------------------------------------------------------------------------
// rbm_cordic: pipelined CORDIC vectoring
// Folds the left half plane onto the right with a start angle of +/-pi,
// then one micro-rotation per stage toward the x axis.
// ----------------------------------------------------------------------------
module rbm_cordic (
  input  logic                           clk,
  input  logic                           en,
  input  logic signed [31:0]             xn,
  input  logic signed [31:0]             yn,
  input  logic                           x_neg,
  input  logic                           y_pos,
  output logic signed [rbm_pkg::Z_W-1:0] z
);
  import rbm_pkg::*;

  logic signed [CX_W-1:0] xs [CORDIC_STEPS+1];
  logic signed [CX_W-1:0] ys [CORDIC_STEPS+1];
  logic signed [Z_W-1:0]  zs [CORDIC_STEPS+1];

  always_ff @(posedge clk) begin
    if (en) begin
      if (x_neg) begin
        xs[0] <= -CX_W'(xn);
        ys[0] <= -CX_W'(yn);
        zs[0] <= y_pos ? Z_W'(PI_Q29) : -Z_W'(PI_Q29);
      end else begin
        xs[0] <= CX_W'(xn);
        ys[0] <= CX_W'(yn);
        zs[0] <= '0;
      end
    end
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    always_ff @(posedge clk) begin
      if (en) begin
        if (!ys[i][CX_W-1]) begin
          xs[i+1] <= xs[i] + (ys[i] >>> i);
          ys[i+1] <= ys[i] - (xs[i] >>> i);
          zs[i+1] <= zs[i] + atan_q29(i);
        end else begin
          xs[i+1] <= xs[i] - (ys[i] >>> i);
          ys[i+1] <= ys[i] + (xs[i] >>> i);
          zs[i+1] <= zs[i] - atan_q29(i);
        end
      end
    end
  end

  assign z = zs[CORDIC_STEPS];

endmodule

>>> src/range_bearing_measurement_model.sv
// ----------------------------------------------------------------------------
// range_bearing_measurement_model: range, bearing and measurement Jacobian
// Converts a Q16.16 position to bearing, range and the four Jacobian terms.
//
//   channel  handshake                  payload
//   pos      pos_valid / pos_ready      rbm_pkg::pos_t  (pos_x, pos_y)
//   meas     meas_valid / meas_ready    rbm_pkg::meas_t (bearing .. at_origin)
//
// One item per cycle while the skid register is empty; an item passes the
// 4-stage front end, the 32-stage square root, one prep stage, the 35-stage
// divider and the output register. The CORDIC runs beside the root and
// divider. Reset clears all valid bits. A held output parks one item in a
// skid register; the whole pipeline freezes only while that register is full.
// ----------------------------------------------------------------------------
module range_bearing_measurement_model (
  input  logic            clk,
  input  logic            rst,
  input  logic            pos_valid,
  output logic            pos_ready,
  input  rbm_pkg::pos_t   pos,
  output logic            meas_valid,
  input  logic            meas_ready,
  output rbm_pkg::meas_t  meas
);
  import rbm_pkg::*;

  localparam int SideDly   = SQRT_STEPS;
  localparam int FlagDly   = SQRT_STEPS + 1 + DIV_LAT;
  localparam int RangeDly  = DIV_LAT;
  localparam int CordicDly = SQRT_STEPS + 1 + DIV_LAT - 1 - CORDIC_STEPS;

  typedef struct packed {
    logic [31:0] ax;
    logic [31:0] ay;
    logic [31:0] axn;
    logic [31:0] ayn;
    logic [63:0] s;
  } side_t;

  function automatic logic [31:0] sat_round(input logic [DIV_QBITS-1:0] q,
                                            input logic ovf, input logic neg);
    logic [31:0] r;
    if (neg) begin
      if (ovf || (q > DIV_QBITS'(34'h080000000))) r = 32'h80000000;
      else r = ~q[31:0] + 32'd1;
    end else begin
      if (ovf || (q > DIV_QBITS'(34'h07FFFFFFF))) r = 32'h7FFFFFFF;
      else r = q[31:0];
    end
    return r;
  endfunction

  logic   en;
  logic   skid_valid;
  meas_t  skid;
  meas_t  res;

  logic   fr_valid;
  front_t fr;

  logic        sq_valid;
  logic [31:0] root_s, root_n;
  logic [33:0] rem_s;

  side_t  side_d  [SideDly];
  flags_t flag_d  [FlagDly];
  logic signed [Z_W-1:0] z_d [CordicDly];
  logic [31:0] rng_d [RangeDly];

  logic signed [Z_W-1:0] z_raw;

  logic        pv;
  logic [63:0] n_bx, n_by, n_rx, n_ry, d_s, d_rn;
  logic [31:0] rng;

  logic                 dv;
  logic [DIV_QBITS-1:0] q_bx, q_by, q_rx, q_ry;
  logic                 o_bx, o_by, o_rx, o_ry;

  logic   take;
  flags_t fl;
  logic signed [Z_W-1:0] zf;

  assign en        = ~skid_valid;
  assign pos_ready = en;

  rbm_front u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (pos_valid),
    .pos       (pos),
    .out_valid (fr_valid),
    .res       (fr)
  );

  rbm_sqrt u_sqrt_s (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (fr_valid),
    .rad       (fr.s),
    .out_valid (sq_valid),
    .root      (root_s),
    .rem       (rem_s)
  );

  rbm_sqrt u_sqrt_n (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (fr_valid),
    .rad       (fr.sn),
    .out_valid (),
    .root      (root_n),
    .rem       ()
  );

  rbm_cordic u_cordic (
    .clk   (clk),
    .en    (en),
    .xn    (fr.xn),
    .yn    (fr.yn),
    .x_neg (fr.flags.x_neg),
    .y_pos (fr.flags.y_pos),
    .z     (z_raw)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      side_d[0] <= '{ax: fr.ax, ay: fr.ay, axn: fr.axn, ayn: fr.ayn, s: fr.s};
      for (int k = 1; k < SideDly; k++) side_d[k] <= side_d[k-1];
      flag_d[0] <= fr.flags;
      for (int k = 1; k < FlagDly; k++) flag_d[k] <= flag_d[k-1];
      z_d[0] <= z_raw;
      for (int k = 1; k < CordicDly; k++) z_d[k] <= z_d[k-1];
      rng_d[0] <= rng;
      for (int k = 1; k < RangeDly; k++) rng_d[k] <= rng_d[k-1];
    end
  end

  // round range to nearest; build rounded numerators
  always_ff @(posedge clk) begin
    if (rst) begin
      pv <= 1'b0;
    end else if (en) begin
      pv <= sq_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rng  <= root_s + {31'd0, (rem_s > {2'b00, root_s})};
      n_bx <= {side_d[SideDly-1].ay, 32'd0} + {1'b0, side_d[SideDly-1].s[63:1]};
      n_by <= {side_d[SideDly-1].ax, 32'd0} + {1'b0, side_d[SideDly-1].s[63:1]};
      n_rx <= {2'b00, side_d[SideDly-1].axn, 30'd0} + {33'd0, root_n[31:1]};
      n_ry <= {2'b00, side_d[SideDly-1].ayn, 30'd0} + {33'd0, root_n[31:1]};
      d_s  <= side_d[SideDly-1].s;
      d_rn <= {32'd0, root_n};
    end
  end

  rbm_div u_div_bx (
    .clk (clk), .rst (rst), .en (en), .in_valid (pv),
    .num (n_bx), .den (d_s), .out_valid (dv), .quo (q_bx), .ovf (o_bx)
  );

  rbm_div u_div_by (
    .clk (clk), .rst (rst), .en (en), .in_valid (pv),
    .num (n_by), .den (d_s), .out_valid (), .quo (q_by), .ovf (o_by)
  );

  rbm_div u_div_rx (
    .clk (clk), .rst (rst), .en (en), .in_valid (pv),
    .num (n_rx), .den (d_rn), .out_valid (), .quo (q_rx), .ovf (o_rx)
  );

  rbm_div u_div_ry (
    .clk (clk), .rst (rst), .en (en), .in_valid (pv),
    .num (n_ry), .den (d_rn), .out_valid (), .quo (q_ry), .ovf (o_ry)
  );

  always_comb begin
    fl  = flag_d[FlagDly-1];
    zf  = z_d[CordicDly-1];
    res = '0;
    if (fl.at_origin) begin
      res.at_origin = 1'b1;
    end else begin
      if (fl.y_zero) begin
        res.bearing = fl.x_neg ? PI_Q29 : 32'sd0;
      end else if (fl.x_zero) begin
        res.bearing = fl.y_pos ? HALF_PI_Q29 : -HALF_PI_Q29;
      end else if (zf > Z_W'(PI_Q29)) begin
        res.bearing = PI_Q29;
      end else if (zf < -Z_W'(PI_Q29)) begin
        res.bearing = -PI_Q29;
      end else begin
        res.bearing = 32'(zf);
      end
      res.range_out   = rng_d[RangeDly-1];
      res.dbearing_dx = sat_round(q_bx, o_bx, fl.y_pos);
      res.dbearing_dy = sat_round(q_by, o_by, fl.x_neg);
      res.drange_dx   = sat_round(q_rx, o_rx, fl.x_neg);
      res.drange_dy   = sat_round(q_ry, o_ry, fl.y_neg);
    end
  end

  assign take = dv & en;

  always_ff @(posedge clk) begin
    if (rst) begin
      meas_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (meas_valid && meas_ready) begin
      if (skid_valid) begin
        skid_valid <= 1'b0;
      end else if (!take) begin
        meas_valid <= 1'b0;
      end
    end else if (take) begin
      if (meas_valid) skid_valid <= 1'b1;
      else meas_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (meas_valid && meas_ready) begin
      if (skid_valid) meas <= skid;
      else if (take) meas <= res;
    end else if (take) begin
      if (meas_valid) skid <= res;
      else meas <= res;
    end
  end

  a_skid_needs_out : assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> meas_valid)
    else $error("skid item held without a valid output item");

  a_origin_zero : assert property (@(posedge clk) disable iff (rst)
    meas_valid && meas.at_origin |->
      meas.bearing == 32'sd0 && meas.range_out == 32'd0 &&
      meas.drange_dx == 32'sd0 && meas.dbearing_dx == 32'sd0)
    else $error("origin item with nonzero fields");

  a_bearing_range : assert property (@(posedge clk) disable iff (rst)
    meas_valid |-> meas.bearing <= PI_Q29 && meas.bearing >= -PI_Q29)
    else $error("bearing outside [-pi, pi]");

  a_skid_drains : assert property (@(posedge clk) disable iff (rst)
    skid_valid && meas_ready |=> !skid_valid)
    else $error("skid item not moved after output accept");

endmodule

>>> tb/sv/range_bearing_measurement_model_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// range_bearing_measurement_model_tb: self-checking testbench
// Drives Q16.16 positions through the valid/ready input channel, predicts
// bearing, range and the measurement Jacobian in bit-exact integer form, and
// checks each result item in order. Directed table, then random items with
// random idling on both sides; the last part of the run runs at full rate.
// ----------------------------------------------------------------------------
module range_bearing_measurement_model_tb;
  import rbm_pkg::*;

  localparam int N_RAND   = 650;
  localparam int LATENCY  = FRONT_LAT + SQRT_STEPS + 1 + DIV_LAT + 1;
  localparam int N_DIR    = 20;

  logic   clk = 1'b0;
  logic   rst = 1'b1;
  logic   pos_valid = 1'b0;
  logic   pos_ready;
  pos_t   pos = '0;
  logic   meas_valid;
  logic   meas_ready = 1'b0;
  meas_t  meas;

  meas_t  pending_meas[$];
  int     errors = 0;
  bit     calm = 1'b0;

  typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] y;
    bit                 fixed;
    meas_t              want;
  } dir_row_t;

  dir_row_t dir_tab[N_DIR];

  always #6 clk = ~clk;

  range_bearing_measurement_model dut (
    .clk(clk), .rst(rst),
    .pos_valid(pos_valid), .pos_ready(pos_ready), .pos(pos),
    .meas_valid(meas_valid), .meas_ready(meas_ready), .meas(meas)
  );

  function automatic longint fshr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic [31:0] rnd_div(longint unsigned num_hi, int sh,
                                          longint unsigned den, bit neg);
    // (num_hi << sh + den/2) / den with 128-bit headroom
    logic [127:0] q;
    if (den == 0) return '0;
    q = ((128'(num_hi) << sh) + 128'(den / 2)) / 128'(den);
    if (neg) begin
      if (q > 128'h8000_0000) q = 128'h8000_0000;
      return -q[31:0];
    end
    if (q > 128'h7FFF_FFFF) q = 128'h7FFF_FFFF;
    return q[31:0];
  endfunction

  function automatic logic signed [31:0] cordic_angle(longint x, longint y);
    longint xs, ys, z, nx, ny;
    xs = x; ys = y; z = 0;
    if (y == 0) return (x > 0) ? 32'sd0 : PI_Q29;
    if (x == 0) return (y > 0) ? HALF_PI_Q29 : -HALF_PI_Q29;
    if (x < 0) begin
      xs = -x; ys = -y;
      z = (y > 0) ? longint'(PI_Q29) : -longint'(PI_Q29);
    end
    for (int i = 0; i < CORDIC_STEPS && i < 32; i++) begin
      if (ys >= 0) begin
        nx = xs + fshr(ys, i); ny = ys - fshr(xs, i);
        z = z + longint'(atan_q29(i));
      end else begin
        nx = xs - fshr(ys, i); ny = ys + fshr(xs, i);
        z = z - longint'(atan_q29(i));
      end
      xs = nx; ys = ny;
    end
    if (z > longint'(PI_Q29)) z = PI_Q29;
    if (z < -longint'(PI_Q29)) z = -longint'(PI_Q29);
    return z[31:0];
  endfunction

  function automatic meas_t polar_of(logic signed [31:0] px, logic signed [31:0] py);
    meas_t m;
    longint x, y, xn, yn;
    longint unsigned ax, ay, s, f, mx, rn, axn, ayn;
    int sh;
    m = '0;
    x = px; y = py;
    if (x == 0 && y == 0) begin
      m.at_origin = 1'b1;
      return m;
    end
    ax = (x < 0) ? -x : x;
    ay = (y < 0) ? -y : y;
    s = ax * ax + ay * ay;
    f = int_sqrt(s);
    if (s - f * f > f) f++;
    mx = (ax > ay) ? ax : ay;
    sh = 0;
    while (mx < (64'd1 << 30)) begin
      mx = mx << 1;
      sh++;
    end
    xn = x * (64'sd1 <<< sh);
    yn = y * (64'sd1 <<< sh);
    axn = (xn < 0) ? -xn : xn;
    ayn = (yn < 0) ? -yn : yn;
    rn = int_sqrt(axn * axn + ayn * ayn);
    m.bearing     = cordic_angle(xn, yn);
    m.range_out   = f[31:0];
    m.dbearing_dx = rnd_div(ay, 32, s, y > 0);
    m.dbearing_dy = rnd_div(ax, 32, s, x < 0);
    m.drange_dx   = rnd_div(axn, 30, rn, x < 0);
    m.drange_dy   = rnd_div(ayn, 30, rn, y < 0);
    return m;
  endfunction

  function automatic meas_t fixed_meas(int brg, int rng, int dbx, int dby,
                                       int drx, int dry, bit org);
    meas_t m;
    m.bearing = brg; m.range_out = rng; m.dbearing_dx = dbx;
    m.dbearing_dy = dby; m.drange_dx = drx; m.drange_dy = dry;
    m.at_origin = org;
    return m;
  endfunction

  task automatic set_row(int i, int x, int y);
    dir_tab[i].x = x;
    dir_tab[i].y = y;
    dir_tab[i].fixed = 1'b0;
  endtask

  initial begin
    set_row(0, 0, 0);
    dir_tab[0].fixed = 1'b1;
    dir_tab[0].want = fixed_meas(0, 0, 0, 0, 0, 0, 1'b1);
    // unit on +x: range 1.0, d bearing/dy = 1.0, d range/dx = 1.0
    set_row(1, 32'h0001_0000, 0);
    dir_tab[1].fixed = 1'b1;
    dir_tab[1].want = fixed_meas(0, 32'h0001_0000, 0, 32'h0001_0000,
                                 32'h4000_0000, 0, 1'b0);
    set_row(2, -32'sh0001_0000, 0);
    dir_tab[2].fixed = 1'b1;
    dir_tab[2].want = fixed_meas(PI_Q29, 32'h0001_0000, 0, -32'sh0001_0000,
                                 -32'sh4000_0000, 0, 1'b0);
    set_row(3, 0, 32'h0001_0000);
    dir_tab[3].fixed = 1'b1;
    dir_tab[3].want = fixed_meas(HALF_PI_Q29, 32'h0001_0000, -32'sh0001_0000, 0,
                                 0, 32'h4000_0000, 1'b0);
    set_row(4, 0, -32'sh0001_0000);
    dir_tab[4].fixed = 1'b1;
    dir_tab[4].want = fixed_meas(-HALF_PI_Q29, 32'h0001_0000, 32'h0001_0000, 0,
                                 0, -32'sh4000_0000, 1'b0);
    set_row(5, 1, 0);
    set_row(6, 0, -1);
    set_row(7, 1, 1);
    set_row(8, -1, -1);
    set_row(9, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    set_row(10, 32'h8000_0000, 32'h8000_0000);
    set_row(11, 32'h8000_0000, 32'h7FFF_FFFF);
    set_row(12, 32'h7FFF_FFFF, 32'h8000_0000);
    set_row(13, 32'h8000_0000, 0);
    set_row(14, 0, 32'h8000_0000);
    set_row(15, -5, 3);
    set_row(16, 32'h0003_0000, 32'h0004_0000);
    set_row(17, -32'sh0003_0000, -32'sh0004_0000);
    set_row(18, 32'h7FFF_FFFF, 1);
    set_row(19, -1, 32'h7FFF_FFFF);
  end

  // valid stays high into the next item unless an idle burst follows
  task automatic send_item(logic signed [31:0] x, logic signed [31:0] y, bit fixed,
                           meas_t want);
    int gap;
    pos.pos_x <= x;
    pos.pos_y <= y;
    pos_valid <= 1'b1;
    pending_meas.push_back(fixed ? want : polar_of(x, y));
    @(posedge clk);
    while (!pos_ready) @(posedge clk);
    @(negedge clk);
    if (!calm && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 7);
      pos_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  function automatic logic signed [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0:       return $urandom_range(0, 64) - 32;
      1:       return $signed($urandom) >>> $urandom_range(8, 31);
      2:       return $urandom_range(0, 1) ? 32'h7FFF_FFFF - $urandom_range(0, 4)
                                          : 32'h8000_0000 + $urandom_range(0, 4);
      3:       return 0;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    for (int i = 0; i < N_DIR; i++)
      send_item(dir_tab[i].x, dir_tab[i].y, dir_tab[i].fixed, dir_tab[i].want);
    pos_valid <= 1'b0;
    // drain before going on
    while (pending_meas.size() != 0) @(negedge clk);
    for (int i = 0; i < N_RAND; i++) begin
      if (i == N_RAND - 150) calm = 1'b1;
      send_item(rand_coord(), rand_coord(), 1'b0, '0);
    end
    pos_valid <= 1'b0;
    while (pending_meas.size() != 0) @(negedge clk);
    repeat (LATENCY + 10) @(negedge clk);
    if (errors == 0) begin
      $display("PASS range_bearing_measurement_model");
    end else begin
      $display("FAIL range_bearing_measurement_model");
    end
    $finish;
  end

  // receiver stalls
  initial begin
    int hold;
    @(negedge clk);
    meas_ready <= 1'b1;
    forever begin
      @(negedge clk);
      if (!calm && $urandom_range(0, 5) == 0) begin
        hold = $urandom_range(1, 7);
        meas_ready <= 1'b0;
        repeat (hold) @(negedge clk);
        meas_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    meas_t want;
    if (!rst && meas_valid && meas_ready) begin
      if (pending_meas.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected item %p", meas);
      end else begin
        want = pending_meas.pop_front();
        if (meas !== want) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: exp %p act %p", want, meas);
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("FAIL range_bearing_measurement_model");
    $finish;
  end

endmodule

>>> range_bearing_measurement_model.f
src/rbm_pkg.sv
src/rbm_front.sv
src/rbm_sqrt.sv
src/rbm_div.sv
src/rbm_cordic.sv
src/range_bearing_measurement_model.sv
tb/sv/range_bearing_measurement_model_tb.sv
